// File: src/gwp_pkg.sv
// shared types, constants and helpers for the gaussian wave packet sample generator
// used by gwp_sincos, gwp_env and gaussian_wave_packet_sample; depends on nothing

package gwp_pkg;

	localparam int COORD_BITS = 10;
	localparam int CFG_W      = 32;

	// pipeline depths of the two sub-units, in register stages
	localparam int SC_LAT  = 14;
	localparam int ENV_LAT = 33;

	localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
	localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
	localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
	localparam logic [31:0] LN2_Q32    = 32'd2977044472;

	// register reset values
	localparam logic [COORD_BITS-1:0] CENTER_X_RST = COORD_BITS'(200);
	localparam logic [COORD_BITS-1:0] CENTER_Y_RST = COORD_BITS'(500);
	localparam logic [23:0]           WAVE_RST     = 24'd1367990;
	localparam logic [15:0]           DIR_RST      = 16'd0;
	localparam logic [31:0]           RATE_RST     = 32'd429497;

	typedef enum logic [2:0] {
		CFG_CENTER_X  = 3'd0,
		CFG_CENTER_Y  = 3'd1,
		CFG_WAVE_NUM  = 3'd2,
		CFG_DIRECTION = 3'd3,
		CFG_ENV_RATE  = 3'd4
	} cfg_idx_t;

	// divisors of the truncating series and their floor(2^32 / d) reciprocals
	localparam int SIN_DIV [3] = '{42, 20, 6};
	localparam int COS_DIV [3] = '{56, 30, 12};
	localparam int EXP_DIV [9] = '{9, 8, 7, 6, 5, 4, 3, 2, 1};

	localparam logic [32:0] SIN_RCP [3] = '{
		33'((64'd1 << 32) / 64'd42), 33'((64'd1 << 32) / 64'd20), 33'((64'd1 << 32) / 64'd6)
	};
	localparam logic [32:0] COS_RCP [3] = '{
		33'((64'd1 << 32) / 64'd56), 33'((64'd1 << 32) / 64'd30), 33'((64'd1 << 32) / 64'd12)
	};
	localparam logic [32:0] EXP_RCP [9] = '{
		33'((64'd1 << 32) / 64'd9), 33'((64'd1 << 32) / 64'd8), 33'((64'd1 << 32) / 64'd7),
		33'((64'd1 << 32) / 64'd6), 33'((64'd1 << 32) / 64'd5), 33'((64'd1 << 32) / 64'd4),
		33'((64'd1 << 32) / 64'd3), 33'((64'd1 << 32) / 64'd2), 33'((64'd1 << 32) / 64'd1)
	};

	typedef struct packed {
		logic [COORD_BITS-1:0] x_coord;
		logic [COORD_BITS-1:0] y_coord;
	} sample_in_t;

	typedef struct packed {
		logic signed [15:0] psi_real;
		logic signed [15:0] psi_imag;
	} sample_out_t;

	// cosine and sine in signed Q2.30
	typedef struct packed {
		logic signed [31:0] c;
		logic signed [31:0] s;
	} trig_t;

	// reciprocal estimate q0 is floor(v/d) or one below; fix it with one compare
	function automatic logic [29:0] div_fix(input logic [29:0] v, input logic [29:0] q0,
		input logic [5:0] d);
		logic [35:0] rem;
		rem = 36'(v) - 36'(q0) * 36'(d);
		return (rem >= 36'(d)) ? q0 + 30'd1 : q0;
	endfunction

endpackage

// File: src/gaussian_wave_packet_sample.sv
// top level of the gaussian wave packet sample generator: registers, pipeline, output skid
// depends on gwp_pkg, gwp_sincos and gwp_env

// Takes one grid point per beat and returns one complex Q1.15 sample per beat: a plane
// wave exp(i*2*pi*phase) under a gaussian envelope, centered on the configured point.
// A new point is taken every clock cycle while the skid register is empty; each result is
// timed by the envelope path: the offset stage, the 33-stage envelope unit and two
// stages of scaling and rounding. The wave path (direction sine/cosine unit, projection,
// phase sine/cosine unit; the two units are 14 stages each) is ready earlier and waits in
// a short delay line. The whole pipeline advances together; a result the output side
// does not take parks in a one-entry skid register, and from the next cycle the pipeline
// and the input stall until that result is taken. Registers are written through a plain
// write port, by the user only while no beat is in flight; the block does not enforce it.

module gaussian_wave_packet_sample (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  gwp_pkg::sample_in_t         sample,
	output logic                        psi_valid,
	input  logic                        psi_ready,
	output gwp_pkg::sample_out_t        psi,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [gwp_pkg::CFG_W-1:0]   cfg_wdata
);

	localparam int CB       = gwp_pkg::COORD_BITS;
	localparam int PROJ_W   = CB + 34;
	localparam int DX_DLY   = gwp_pkg::SC_LAT - 1;
	// trig ready at stage PH_AT, envelope at ENV_AT
	localparam int PH_AT    = 2 * gwp_pkg::SC_LAT + 3;
	localparam int ENV_AT   = 1 + gwp_pkg::ENV_LAT;
	localparam int TRIG_DLY = ENV_AT - PH_AT;
	localparam int OUT_AT   = ENV_AT + 2;

	// configuration registers
	logic [CB-1:0] center_x_q, center_y_q;
	logic [23:0]   wave_q;
	logic [15:0]   direction_q;
	logic [31:0]   rate_q;

	// pipeline control
	logic en;
	logic vld_s [OUT_AT];
	logic skid_vld_q;
	gwp_pkg::sample_out_t skid_q;

	// payload
	logic signed [CB:0] dx_s1, dy_s1;
	logic signed [CB:0] dx_dl [DX_DLY], dy_dl [DX_DLY];
	gwp_pkg::trig_t dir_trig, ph_trig;
	gwp_pkg::trig_t trig_dl [TRIG_DLY];
	logic signed [PROJ_W-1:0] proj_s15;
	logic [53:0] proj54;
	logic [50:0] plo_s16;
	logic [26:0] phi_s16;
	logic [53:0] phase_sum;
	logic [31:0] phase_s17;
	logic [30:0] env;
	logic        c_neg, s_neg;
	logic [30:0] c_mag, s_mag;
	logic        c_neg_s35, s_neg_s35;
	logic [61:0] pc_s35, ps_s35;
	gwp_pkg::sample_out_t out_s36;

	// round half away from zero in sign/magnitude, then clamp
	function automatic logic signed [15:0] sat_q15(input logic [61:0] prod, input logic neg);
		logic [61:0] rs;
		logic [16:0] r;
		rs = prod + (62'd1 << 44);
		r  = rs[61:45];
		if (neg) begin
			if (r > 17'd32768) r = 17'd32768;
			return 16'(17'd0 - r);
		end
		if (r > 17'd32767) r = 17'd32767;
		return 16'(r);
	endfunction

	// register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= gwp_pkg::CENTER_X_RST;
			center_y_q  <= gwp_pkg::CENTER_Y_RST;
			wave_q      <= gwp_pkg::WAVE_RST;
			direction_q <= gwp_pkg::DIR_RST;
			rate_q      <= gwp_pkg::RATE_RST;
		end else if (cfg_we) begin
			unique case (gwp_pkg::cfg_idx_t'(cfg_index))
				gwp_pkg::CFG_CENTER_X:  center_x_q  <= cfg_wdata[CB-1:0];
				gwp_pkg::CFG_CENTER_Y:  center_y_q  <= cfg_wdata[CB-1:0];
				gwp_pkg::CFG_WAVE_NUM:  wave_q      <= cfg_wdata[23:0];
				gwp_pkg::CFG_DIRECTION: direction_q <= cfg_wdata[15:0];
				gwp_pkg::CFG_ENV_RATE:  rate_q      <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	// whole pipe moves unless the skid register is occupied
	assign en           = !skid_vld_q;
	assign sample_ready = en;
	assign psi_valid    = skid_vld_q || vld_s[OUT_AT-1];
	assign psi          = skid_vld_q ? skid_q : out_s36;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < OUT_AT; k++) vld_s[k] <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (en) begin
				vld_s[0] <= sample_valid;
				for (int k = 1; k < OUT_AT; k++) vld_s[k] <= vld_s[k-1];
			end
			if (skid_vld_q) begin
				if (psi_ready) skid_vld_q <= 1'b0;
			end else if (vld_s[OUT_AT-1] && !psi_ready) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	// result not taken at the last stage parks here
	always_ff @(posedge clk) begin
		if (en && vld_s[OUT_AT-1] && !psi_ready) skid_q <= out_s36;
	end

	// offsets from the packet center
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({1'b0, sample.x_coord}) - $signed({1'b0, center_x_q});
			dy_s1 <= $signed({1'b0, sample.y_coord}) - $signed({1'b0, center_y_q});
			dx_dl[0] <= dx_s1;
			dy_dl[0] <= dy_s1;
			for (int k = 1; k < DX_DLY; k++) begin
				dx_dl[k] <= dx_dl[k-1];
				dy_dl[k] <= dy_dl[k-1];
			end
		end
	end

	// direction cos/sin runs in step with each beat
	gwp_sincos u_dir_sc (
		.clk   (clk),
		.en    (en),
		.phase ({direction_q, 16'h0000}),
		.trig  (dir_trig)
	);

	gwp_env u_env (
		.clk  (clk),
		.en   (en),
		.dx   (dx_s1),
		.dy   (dy_s1),
		.rate (rate_q),
		.env  (env)
	);

	// projection onto the direction, then phase = bits 22..53 of proj * k
	assign proj54    = 54'(proj_s15);
	assign phase_sum = 54'(plo_s16) + {phi_s16, 27'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			proj_s15  <= PROJ_W'(dx_dl[DX_DLY-1]) * PROJ_W'(dir_trig.c)
				+ PROJ_W'(dy_dl[DX_DLY-1]) * PROJ_W'(dir_trig.s);
			plo_s16   <= 51'(proj54[26:0]) * 51'(wave_q);
			phi_s16   <= 27'(proj54[53:27]) * 27'(wave_q);
			phase_s17 <= phase_sum[53:22];
		end
	end

	gwp_sincos u_ph_sc (
		.clk   (clk),
		.en    (en),
		.phase (phase_s17),
		.trig  (ph_trig)
	);

	// line the wave up with the longer envelope path
	always_ff @(posedge clk) begin
		if (en) begin
			trig_dl[0] <= ph_trig;
			for (int k = 1; k < TRIG_DLY; k++) trig_dl[k] <= trig_dl[k-1];
		end
	end

	assign c_neg = trig_dl[TRIG_DLY-1].c[31];
	assign s_neg = trig_dl[TRIG_DLY-1].s[31];
	assign c_mag = c_neg ? 31'(-trig_dl[TRIG_DLY-1].c) : 31'(trig_dl[TRIG_DLY-1].c);
	assign s_mag = s_neg ? 31'(-trig_dl[TRIG_DLY-1].s) : 31'(trig_dl[TRIG_DLY-1].s);

	// envelope times wave, then round and saturate to Q1.15
	always_ff @(posedge clk) begin
		if (en) begin
			pc_s35    <= 62'(env) * 62'(c_mag);
			ps_s35    <= 62'(env) * 62'(s_mag);
			c_neg_s35 <= c_neg;
			s_neg_s35 <= s_neg;
			out_s36   <= '{psi_real: sat_q15(pc_s35, c_neg_s35),
				psi_imag: sat_q15(ps_s35, s_neg_s35)};
		end
	end

endmodule

// File: src/gwp_sincos.sv
// pipelined cosine and sine of a Q0.32 turn angle, octant fold and truncating series
// depends on gwp_pkg

module gwp_sincos (
	input  logic                clk,
	input  logic                en,
	input  logic [31:0]         phase,
	output gwp_pkg::trig_t      trig
);

	typedef struct packed {
		logic [1:0]  q;
		logic        sw;
		logic [29:0] x;
		logic [29:0] xx;
	} sc_ctx_t;

	logic [1:0]  q_s1, q_s2;
	logic        sw_s1, sw_s2;
	logic [29:0] f_s1, x_s2;
	sc_ctx_t     ctx_s3;

	// series steps, three stages each
	sc_ctx_t     src_ctx [3];
	logic [30:0] src_st [3], src_ct [3];
	sc_ctx_t     m_ctx [3], a_ctx [3], b_ctx [3];
	logic [29:0] m_sp [3], m_cp [3], a_sp [3], a_cp [3], a_sq [3], a_cq [3];
	logic [30:0] b_st [3], b_ct [3];

	logic [1:0]  q_s13;
	logic        sw_s13;
	logic [29:0] sn_s13, cp_s13;
	logic [30:0] cs_full, sn_full;
	logic signed [31:0] va, vb;
	gwp_pkg::trig_t out_s14;

	logic [29:0] r_in;
	logic        sw_in;

	assign r_in  = phase[29:0];
	assign sw_in = r_in > 30'h2000_0000;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1   <= phase[31:30];
			sw_s1  <= sw_in;
			f_s1   <= sw_in ? 30'(31'h4000_0000 - 31'(r_in)) : r_in;
			q_s2   <= q_s1;
			sw_s2  <= sw_s1;
			x_s2   <= 30'((62'(f_s1) * 62'(gwp_pkg::TWO_PI_Q29)) >> 31);
			ctx_s3 <= '{q: q_s2, sw: sw_s2, x: x_s2, xx: 30'((60'(x_s2) * 60'(x_s2)) >> 30)};
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_step
		if (j == 0) begin : g_first
			assign src_ctx[j] = ctx_s3;
			assign src_st[j]  = gwp_pkg::ONE_Q30;
			assign src_ct[j]  = gwp_pkg::ONE_Q30;
		end else begin : g_next
			assign src_ctx[j] = b_ctx[j-1];
			assign src_st[j]  = b_st[j-1];
			assign src_ct[j]  = b_ct[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_ctx[j] <= src_ctx[j];
				m_sp[j]  <= 30'((61'(src_ctx[j].xx) * 61'(src_st[j])) >> 30);
				m_cp[j]  <= 30'((61'(src_ctx[j].xx) * 61'(src_ct[j])) >> 30);
				a_ctx[j] <= m_ctx[j];
				a_sp[j]  <= m_sp[j];
				a_cp[j]  <= m_cp[j];
				a_sq[j]  <= 30'((63'(m_sp[j]) * 63'(gwp_pkg::SIN_RCP[j])) >> 32);
				a_cq[j]  <= 30'((63'(m_cp[j]) * 63'(gwp_pkg::COS_RCP[j])) >> 32);
				b_ctx[j] <= a_ctx[j];
				b_st[j]  <= gwp_pkg::ONE_Q30
					- 31'(gwp_pkg::div_fix(a_sp[j], a_sq[j], 6'(gwp_pkg::SIN_DIV[j])));
				b_ct[j]  <= gwp_pkg::ONE_Q30
					- 31'(gwp_pkg::div_fix(a_cp[j], a_cq[j], 6'(gwp_pkg::COS_DIV[j])));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s13  <= b_ctx[2].q;
			sw_s13 <= b_ctx[2].sw;
			sn_s13 <= 30'((61'(b_ctx[2].x) * 61'(b_st[2])) >> 30);
			cp_s13 <= 30'((61'(b_ctx[2].xx) * 61'(b_ct[2])) >> 30);
			out_s14 <= '{c: va, s: vb};
		end
	end

	// undo the octant fold, then the quadrant
	always_comb begin
		logic signed [31:0] a, b;
		cs_full = gwp_pkg::ONE_Q30 - 31'(cp_s13 >> 1);
		sn_full = 31'(sn_s13);
		a = sw_s13 ? $signed(32'(sn_full)) : $signed(32'(cs_full));
		b = sw_s13 ? $signed(32'(cs_full)) : $signed(32'(sn_full));
		case (q_s13)
			2'd0: begin
				va = a;
				vb = b;
			end
			2'd1: begin
				va = -b;
				vb = a;
			end
			2'd2: begin
				va = -a;
				vb = -b;
			end
			default: begin
				va = b;
				vb = -a;
			end
		endcase
	end

	assign trig = out_s14;

endmodule

// File: src/gwp_env.sv
// pipelined gaussian envelope exp(-(dx^2+dy^2)*rate) in Q2.30, zero below 2^-16
// depends on gwp_pkg

module gwp_env (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [gwp_pkg::COORD_BITS:0] dx,
	input  logic signed [gwp_pkg::COORD_BITS:0] dy,
	input  logic [31:0]                         rate,
	output logic [30:0]                         env
);

	localparam int CB   = gwp_pkg::COORD_BITS;
	localparam int SQ_W = 2 * CB + 2;
	localparam int R2_W = (2 * CB + 1 > 17) ? 2 * CB + 1 : 17;
	localparam int PH_W = R2_W + 16;

	typedef struct packed {
		logic [29:0] y;
		logic [4:0]  n;
		logic        zero;
	} env_ctx_t;

	logic signed [SQ_W-1:0] sqx, sqy;
	logic [R2_W-1:0] r2_s1;
	logic [PH_W-1:0] ph_s2;
	logic [47:0]     pl_s2;
	logic            big_s3, zero_s4;
	logic [48:0]     a_s3;
	logic [36:0]     b_s4;
	env_ctx_t        ctx_s5;

	env_ctx_t    src_ctx [9], m_ctx [9], a_ctx [9], b_ctx [9];
	logic [30:0] src_t [9], b_t [9];
	logic [29:0] m_p [9], a_p [9], a_q [9];

	logic [4:0]  n_e4;
	logic [30:0] tt;
	logic [30:0] env_s33;

	assign sqx  = SQ_W'(dx) * SQ_W'(dx);
	assign sqy  = SQ_W'(dy) * SQ_W'(dy);
	assign n_e4 = b_s4[36:32];

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s1  <= R2_W'(unsigned'(sqx)) + R2_W'(unsigned'(sqy));
			ph_s2  <= PH_W'(r2_s1[R2_W-1:16]) * PH_W'(rate);
			pl_s2  <= 48'(r2_s1[15:0]) * 48'(rate);
			// the high partial product alone decides the far tail
			big_s3 <= ph_s2 >= PH_W'(12 << 16);
			a_s3   <= 49'(pl_s2) + ({9'd0, ph_s2[19:0], 20'd0} >> 4);
			zero_s4 <= big_s3 || (a_s3 >= (49'd12 << 32));
			b_s4    <= 37'((63'(a_s3[35:4]) * 63'(gwp_pkg::LOG2E_Q30)) >> 26);
			ctx_s5  <= '{y: 30'((64'(b_s4[31:0]) * 64'(gwp_pkg::LN2_Q32)) >> 34),
				n: n_e4, zero: zero_s4 || (n_e4 > 5'd16)};
		end
	end

	// series for exp(-y), one term per three stages
	for (genvar j = 0; j < 9; j++) begin : g_term
		if (j == 0) begin : g_first
			assign src_ctx[j] = ctx_s5;
			assign src_t[j]   = gwp_pkg::ONE_Q30;
		end else begin : g_next
			assign src_ctx[j] = b_ctx[j-1];
			assign src_t[j]   = b_t[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_ctx[j] <= src_ctx[j];
				m_p[j]   <= 30'((61'(src_ctx[j].y) * 61'(src_t[j])) >> 30);
				a_ctx[j] <= m_ctx[j];
				a_p[j]   <= m_p[j];
				a_q[j]   <= 30'((63'(m_p[j]) * 63'(gwp_pkg::EXP_RCP[j])) >> 32);
				b_ctx[j] <= a_ctx[j];
				b_t[j]   <= gwp_pkg::ONE_Q30
					- 31'(gwp_pkg::div_fix(a_p[j], a_q[j], 6'(gwp_pkg::EXP_DIV[j])));
			end
		end
	end

	assign tt = b_t[8] >> b_ctx[8].n;

	always_ff @(posedge clk) begin
		if (en) begin
			env_s33 <= (b_ctx[8].zero || tt < 31'(1 << 14)) ? '0 : tt;
		end
	end

	assign env = env_s33;

endmodule

// File: bench/gaussian_wave_packet_sample_tb.sv
// self-checking bench for gaussian_wave_packet_sample: directed table then random grid points
// depends on gwp_pkg and the gaussian_wave_packet_sample rtl; needs no files or arguments
`timescale 1ns / 1ps

module gaussian_wave_packet_sample_tb;

	localparam int CB = gwp_pkg::COORD_BITS;

	// math constants of the fixed-point recipe, kept local to the bench
	localparam bit [63:0] Q30_ONE   = 64'd1 << 30;
	localparam bit [63:0] TWO_PI_29 = 64'd3373259426;
	localparam bit [63:0] LOG2E_30  = 64'd1549082005;
	localparam bit [63:0] LN2_32    = 64'd2977044472;

	// register slots past the last real one, written to show they are ignored
	localparam logic [2:0] SPARE_IDX_FIRST = 3'd5;
	localparam logic [2:0] SPARE_IDX_LAST  = 3'd7;

	localparam int SETTLE_CYCLES = 48;	// margin past the end of the pipeline

	typedef struct {
		bit [CB-1:0] cx;
		bit [CB-1:0] cy;
		bit [23:0]   wave;
		bit [15:0]   dir;
		bit [31:0]   rate;
	} packet_cfg_t;

	typedef struct {
		bit [CB-1:0]         x;
		bit [CB-1:0]         y;
		bit                  known;	// expected sample typed in below
		logic signed [15:0]  re;
		logic signed [15:0]  im;
	} point_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 sample_valid;
	logic                 sample_ready;
	gwp_pkg::sample_in_t  sample;
	logic                 psi_valid;
	logic                 psi_ready;
	gwp_pkg::sample_out_t psi;
	logic                 cfg_we;
	logic [2:0]           cfg_index;
	logic [gwp_pkg::CFG_W-1:0] cfg_wdata;

	packet_cfg_t          packet;			// bench copy of the register file
	gwp_pkg::sample_out_t pending_samples[$];	// expected psi beats, oldest first
	int                   errors;
	int                   idle_pct;
	int                   stall_pct;
	int                   hold_cycles;		// long receiver hold-off, counted down below

	gaussian_wave_packet_sample dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.psi_valid    (psi_valid),
		.psi_ready    (psi_ready),
		.psi          (psi),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------- sample model

	// sin and cos of one octant angle f (q0.32 turns), both q2.30
	function automatic void octant_sincos(input bit [31:0] f, output bit [63:0] sn,
		output bit [63:0] cs);
		bit [63:0] x, x2, t;
		x  = (64'(f) * TWO_PI_29) >> 31;
		x2 = (x * x) >> 30;
		t  = Q30_ONE - x2 / 42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 6;
		sn = (x * t) >> 30;
		t  = Q30_ONE - x2 / 56;
		t  = Q30_ONE - ((x2 * t) >> 30) / 30;
		t  = Q30_ONE - ((x2 * t) >> 30) / 12;
		cs = Q30_ONE - ((x2 * t) >> 30) / 2;
	endfunction

	// full-turn cos and sin, signed q2.30; quadrant folds are exact
	function automatic void turn_cos_sin(input bit [31:0] p, output longint c,
		output longint s);
		bit [1:0]  quad;
		bit [31:0] r;
		bit [63:0] sn, cs;
		longint    a, b;
		quad = p[31:30];
		r    = {2'b00, p[29:0]};
		if (r <= 32'h2000_0000) begin
			octant_sincos(r, sn, cs);
		end else begin
			octant_sincos(32'h4000_0000 - r, cs, sn);
		end
		a = longint'(cs);
		b = longint'(sn);
		case (quad)
			2'd0: begin c = a;  s = b;  end
			2'd1: begin c = -b; s = a;  end
			2'd2: begin c = -a; s = -b; end
			default: begin c = b; s = -a; end
		endcase
	endfunction

	// exp(-a) for a in q.32, result q2.30, flushed to zero under 2^-16
	function automatic bit [63:0] gauss_envelope(input bit [63:0] a);
		bit [63:0] b, y, t;
		bit [31:0] n;
		if (a >= (64'd12 << 32))
			return 64'd0;
		b = ((a >> 4) * LOG2E_30) >> 26;
		n = b[63:32];
		if (n > 16)
			return 64'd0;
		y = ((b & 64'hFFFF_FFFF) * LN2_32) >> 34;
		t = Q30_ONE;
		for (int k = 9; k >= 1; k--)
			t = Q30_ONE - ((y * t) >> 30) / k;
		t = t >> n;
		if (t < (64'd1 << 14))
			return 64'd0;
		return t;
	endfunction

	// envelope times trig value into q1.15, rounded half away, saturated
	function automatic logic [15:0] scale_q15(input bit [63:0] env, input longint v);
		bit        neg;
		bit [63:0] m, r;
		neg = v < 0;
		m   = neg ? 64'(-v) : 64'(v);
		r   = (env * m + (64'd1 << 44)) >> 45;
		if (neg) begin
			if (r > 32768)
				r = 32768;
			return 16'(64'd0 - r);
		end
		if (r > 32767)
			r = 32767;
		return r[15:0];
	endfunction

	function automatic gwp_pkg::sample_out_t wave_packet_at(input bit [CB-1:0] x,
		input bit [CB-1:0] y);
		int                   dx, dy;
		longint               dc, ds, pc, ps, proj;
		bit [63:0]            proj_u, r2, a, env;
		bit [31:0]            phase;
		gwp_pkg::sample_out_t res;
		dx = int'(x) - int'(packet.cx);
		dy = int'(y) - int'(packet.cy);
		turn_cos_sin({packet.dir, 16'h0000}, dc, ds);
		proj   = longint'(dx) * dc + longint'(dy) * ds;
		proj_u = proj;
		phase  = 32'((proj_u * 64'(packet.wave)) >> 22);
		r2 = 64'(dx * dx) + 64'(dy * dy);
		if ((r2 >> 16) * 64'(packet.rate) >= (64'd12 << 16))
			a = 64'd12 << 32;
		else
			a = r2 * 64'(packet.rate);
		env = gauss_envelope(a);
		turn_cos_sin(phase, pc, ps);
		res.psi_real = scale_q15(env, pc);
		res.psi_imag = scale_q15(env, ps);
		return res;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		$display("%0t: psi %s mismatch: got %0d, expected %0d", $realtime, what,
			$signed(got), $signed(want));
		errors++;
	endtask

	// compare each accepted psi beat with the oldest pending sample
	always @(posedge clk) begin
		gwp_pkg::sample_out_t want;
		if (arst_n && psi_valid && psi_ready) begin
			if (pending_samples.size() == 0) begin
				$display("%0t: psi beat with nothing pending", $realtime);
				errors++;
			end else begin
				want = pending_samples.pop_front();
				if (psi.psi_real !== want.psi_real)
					report_mismatch("real", psi.psi_real, want.psi_real);
				if (psi.psi_imag !== want.psi_imag)
					report_mismatch("imag", psi.psi_imag, want.psi_imag);
			end
		end
	end

	// receiver: random stalls, or a long hold-off while hold_cycles runs down
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			psi_ready <= 1'b0;
		end else begin
			psi_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ---------------------------------------------------------------- driving

	// one grid point; valid stays up across back-to-back beats
	task automatic send_point(input bit [CB-1:0] x, input bit [CB-1:0] y,
		input bit known, input gwp_pkg::sample_out_t typed);
		if ($urandom_range(99) < idle_pct) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		sample_valid   <= 1'b1;
		sample.x_coord <= x;
		sample.y_coord <= y;
		pending_samples.push_back(known ? typed : wave_packet_at(x, y));
		do
			@(posedge clk);
		while (!sample_ready);
	endtask

	// write all five registers, plus one spare slot the block must ignore
	task automatic load_packet(input bit [31:0] vals[5]);
		gwp_pkg::cfg_idx_t idx;
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			if (i < 5) begin
				idx = gwp_pkg::cfg_idx_t'(i);
				cfg_index <= idx;
				cfg_wdata <= vals[i];
				case (idx)
					gwp_pkg::CFG_CENTER_X:  packet.cx   = vals[i][CB-1:0];
					gwp_pkg::CFG_CENTER_Y:  packet.cy   = vals[i][CB-1:0];
					gwp_pkg::CFG_WAVE_NUM:  packet.wave = vals[i][23:0];
					gwp_pkg::CFG_DIRECTION: packet.dir  = vals[i][15:0];
					gwp_pkg::CFG_ENV_RATE:  packet.rate = vals[i];
					default: ;
				endcase
			end else begin
				cfg_index <= 3'($urandom_range(SPARE_IDX_LAST, SPARE_IDX_FIRST));
				cfg_wdata <= $urandom;
			end
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic drain_pipeline();
		sample_valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly points near the centre, where the envelope is alive
	task automatic random_point(output bit [CB-1:0] x, output bit [CB-1:0] y);
		int span;
		if ($urandom_range(3) == 0) begin
			x = $urandom;
			y = $urandom;
		end else begin
			span = ($urandom_range(1) == 0) ? 8 : 64;
			x = packet.cx + CB'($urandom_range(2 * span) - span);
			y = packet.cy + CB'($urandom_range(2 * span) - span);
		end
	endtask

	// ---------------------------------------------------------------- directed table

	// reset config: centre (200,500); far corners fall under the envelope cutoff
	point_row_t directed_rows[] = '{
		'{10'd200,  10'd500,  1'b1, 16'sd32767, 16'sd0},	// centre, saturates at +1
		'{10'd0,    10'd0,    1'b1, 16'sd0,     16'sd0},
		'{10'd1023, 10'd1023, 1'b1, 16'sd0,     16'sd0},
		'{10'd1023, 10'd0,    1'b1, 16'sd0,     16'sd0},
		'{10'd0,    10'd1023, 1'b1, 16'sd0,     16'sd0},
		'{10'd201,  10'd500,  1'b0, 16'sd0,     16'sd0},
		'{10'd199,  10'd500,  1'b0, 16'sd0,     16'sd0},
		'{10'd200,  10'd501,  1'b0, 16'sd0,     16'sd0},
		'{10'd200,  10'd499,  1'b0, 16'sd0,     16'sd0},
		'{10'd210,  10'd490,  1'b0, 16'sd0,     16'sd0},
		'{10'd230,  10'd520,  1'b0, 16'sd0,     16'sd0},
		'{10'd260,  10'd500,  1'b0, 16'sd0,     16'sd0},
		'{10'd140,  10'd440,  1'b0, 16'sd0,     16'sd0},
		'{10'd400,  10'd500,  1'b0, 16'sd0,     16'sd0},
		'{10'd200,  10'd800,  1'b0, 16'sd0,     16'sd0}
	};

	// ---------------------------------------------------------------- main sequence

	initial begin
		bit [31:0] vals[5];
		bit [CB-1:0] x, y;
		gwp_pkg::sample_out_t typed;

		errors       = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_cycles  = 0;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		psi_ready    = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = gwp_pkg::CFG_CENTER_X;
		cfg_wdata    = '0;
		packet.cx    = 10'd200;
		packet.cy    = 10'd500;
		packet.wave  = 24'd1367990;
		packet.dir   = 16'd0;
		packet.rate  = 32'd429497;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows against the reset registers, no idling
		foreach (directed_rows[i]) begin
			typed.psi_real = directed_rows[i].re;
			typed.psi_imag = directed_rows[i].im;
			send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].known, typed);
		end
		drain_pipeline();

		// random phases: extremes first, then random registers, rotating idle and stall modes
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: vals = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
				1: vals = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
					32'hFFFF_FFFF};
				2: vals = '{32'd512, 32'd512, 32'hFF_FFFF, 32'h8000, 32'd0};
				default: begin
					vals[0] = $urandom;
					vals[1] = $urandom;
					vals[2] = $urandom;
					vals[3] = $urandom;
					case ($urandom_range(3))
						0: vals[4] = $urandom;
						1: vals[4] = $urandom_range(1 << 20);
						default: vals[4] = $urandom_range(1 << 16);
					endcase
				end
			endcase
			load_packet(vals);

			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 56; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 56; end
				default: begin idle_pct = 22; stall_pct = 22; end
			endcase

			// long receiver hold-off while the sender keeps pushing
			if (ph == 4)
				hold_cycles = 400;

			for (int n = 0; n < 50; n++) begin
				random_point(x, y);
				send_point(x, y, 1'b0, typed);
				// sender pauses until all pending samples are out
				if (ph == 5 && n == 25) begin
					sample_valid <= 1'b0;
					while (pending_samples.size() != 0)
						@(posedge clk);
				end
			end
			drain_pipeline();
		end

		if (errors == 0)
			$display("gaussian_wave_packet_sample_tb: clean");
		else
			$display("gaussian_wave_packet_sample_tb: errors");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("gaussian_wave_packet_sample_tb: errors");
		$finish;
	end

endmodule
